@@ src/pis_pkg.sv @@
// Shared types and constants for the point-in-sphere set test block.
`default_nettype none

package pis_pkg;

  localparam int unsigned MAX_SPHERES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF  = 10;
  localparam int unsigned KIND_BITS       = 2;

  // Command class decided by the front end.
  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

endpackage

`default_nettype wire

@@ src/point_in_sphere_set_test.sv @@
// Top level of the point-in-sphere set test block.
// Usage:
//   Input channel: drive func and the payload with push; the item transfers
//   on a clock edge with push high and full low. func 0 adds a sphere (center,
//   radius, kind), func 1 queries whether a point lies strictly inside any
//   stored sphere of the given kind.
//   Result channel: while empty is low, hit and status show the oldest result;
//   it transfers on an edge with pop high. Exactly one result per item, in order.
//   An add is executed when the back end takes it from the queue, and its result is
//   registered. A query scans the table one entry per cycle through a registered
//   RAM read and a two-stage square/compare pipeline, over all N stored spheres
//   (at most MAX_SPHERES). Items are processed one at a time by the back end;
//   a two-entry input queue keeps taking items meanwhile.
//   An add to a full table is dropped and reports status 1.
//   Reset (rst, synchronous) empties the table, the input queue and the result register.
//   When pop stays low, the result is held, the back end stops once its next
//   result is ready, and full rises when the input queue fills.
`default_nettype none

module point_in_sphere_set_test #(
  parameter int unsigned MAX_SPHERES = pis_pkg::MAX_SPHERES_DEF,
  parameter int unsigned COORD_BITS  = pis_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           func,
  input  wire logic [COORD_BITS-1:0]          coord_x,
  input  wire logic [COORD_BITS-1:0]          coord_y,
  input  wire logic [COORD_BITS-1:0]          coord_z,
  input  wire logic [COORD_BITS-1:0]          radius,
  input  wire logic [pis_pkg::KIND_BITS-1:0]  kind,
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                hit,
  output logic                                status
);

  logic                          cmd_valid;
  pis_pkg::op_t                  cmd_op;
  logic [COORD_BITS-1:0]         cmd_x;
  logic [COORD_BITS-1:0]         cmd_y;
  logic [COORD_BITS-1:0]         cmd_z;
  logic [COORD_BITS-1:0]         cmd_r;
  logic [pis_pkg::KIND_BITS-1:0] cmd_kind;
  logic                          cmd_take;

  pis_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .radius    (radius),
    .kind      (kind),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .cmd_z     (cmd_z),
    .cmd_r     (cmd_r),
    .cmd_kind  (cmd_kind),
    .cmd_take  (cmd_take)
  );

  pis_back #(
    .MAX_SPHERES (MAX_SPHERES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .cmd_z     (cmd_z),
    .cmd_r     (cmd_r),
    .cmd_kind  (cmd_kind),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .hit       (hit),
    .status    (status)
  );

endmodule

`default_nettype wire

@@ src/pis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/pis_front.sv @@
// Front end: accepts items, classifies them and holds them in a two-entry queue.
`default_nettype none

module pis_front #(
  parameter int unsigned COORD_BITS = pis_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           func,
  input  wire logic [COORD_BITS-1:0]          coord_x,
  input  wire logic [COORD_BITS-1:0]          coord_y,
  input  wire logic [COORD_BITS-1:0]          coord_z,
  input  wire logic [COORD_BITS-1:0]          radius,
  input  wire logic [pis_pkg::KIND_BITS-1:0]  kind,
  output logic                                cmd_valid,
  output pis_pkg::op_t                        cmd_op,
  output logic      [COORD_BITS-1:0]          cmd_x,
  output logic      [COORD_BITS-1:0]          cmd_y,
  output logic      [COORD_BITS-1:0]          cmd_z,
  output logic      [COORD_BITS-1:0]          cmd_r,
  output logic      [pis_pkg::KIND_BITS-1:0]  cmd_kind,
  input  wire logic                           cmd_take
);

  localparam int unsigned PW = 4 * COORD_BITS + pis_pkg::KIND_BITS;

  logic [PW-1:0]       q_data [2];
  pis_pkg::op_t        q_op   [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;
  logic                push_fire;
  logic                take_fire;
  pis_pkg::op_t        op_in;
  logic [PW-1:0]       rd_data;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign push_fire = push && !full;
  assign take_fire = cmd_take && cmd_valid;

  always_comb begin
    unique case (func)
      1'b0:    op_in = pis_pkg::OP_ADD;
      default: op_in = pis_pkg::OP_QUERY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_fire, take_fire})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_data[wr_ptr] <= {kind, radius, coord_z, coord_y, coord_x};
      q_op[wr_ptr]   <= op_in;
    end
  end

  assign rd_data = q_data[rd_ptr];
  assign cmd_op  = q_op[rd_ptr];
  assign {cmd_kind, cmd_r, cmd_z, cmd_y, cmd_x} = rd_data;

endmodule

`default_nettype wire

@@ src/pis_back.sv @@
// Back end: sphere table, add execution, query scan pipeline and result register.
`default_nettype none

module pis_back #(
  parameter int unsigned MAX_SPHERES = pis_pkg::MAX_SPHERES_DEF,
  parameter int unsigned COORD_BITS  = pis_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  input  wire pis_pkg::op_t                   cmd_op,
  input  wire logic [COORD_BITS-1:0]          cmd_x,
  input  wire logic [COORD_BITS-1:0]          cmd_y,
  input  wire logic [COORD_BITS-1:0]          cmd_z,
  input  wire logic [COORD_BITS-1:0]          cmd_r,
  input  wire logic [pis_pkg::KIND_BITS-1:0]  cmd_kind,
  output logic                                cmd_take,
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                hit,
  output logic                                status
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned KB = pis_pkg::KIND_BITS;
  localparam int unsigned EW = 4 * CB + KB;
  localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned SW = 2 * CB + 2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   scan_idx;
  logic            tbl_full;

  // query operands
  logic [CB-1:0]   px;
  logic [CB-1:0]   py;
  logic [CB-1:0]   pz;
  logic [KB-1:0]   pkind;

  // table port
  logic            we;
  logic [EW-1:0]   wdata;
  logic [EW-1:0]   rdata;

  // scan pipeline
  logic            v_rd;
  logic            v_sq;
  logic            issue;
  logic [2*CB-1:0] sqx;
  logic [2*CB-1:0] sqy;
  logic [2*CB-1:0] sqz;
  logic [2*CB-1:0] r2;
  logic            kmatch;
  logic            hit_acc;
  logic [CB-1:0]   ex;
  logic [CB-1:0]   ey;
  logic [CB-1:0]   ez;
  logic [CB-1:0]   er;
  logic [KB-1:0]   ek;
  logic [CB-1:0]   dx;
  logic [CB-1:0]   dy;
  logic [CB-1:0]   dz;
  logic [SW-1:0]   d2;
  logic            scan_done;

  // result register
  logic            res_valid;
  logic            pop_fire;
  logic            slot_free;
  logic            res_load;
  logic            add_fire;

  assign tbl_full  = (count == CW'(MAX_SPHERES));
  assign pop_fire  = pop && res_valid;
  assign slot_free = !res_valid || pop_fire;
  assign empty     = !res_valid;

  assign add_fire = (state == S_IDLE) && cmd_valid && (cmd_op == pis_pkg::OP_ADD) && slot_free;
  assign cmd_take = (state == S_IDLE) && cmd_valid
                    && ((cmd_op == pis_pkg::OP_QUERY) || slot_free);

  assign issue     = (state == S_SCAN) && (scan_idx < count);
  assign scan_done = (state == S_SCAN) && !issue && !v_rd && !v_sq;
  assign res_load  = add_fire || ((state == S_DONE) && slot_free);

  assign we    = add_fire && !tbl_full;
  assign wdata = {cmd_kind, cmd_r, cmd_z, cmd_y, cmd_x};

  pis_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SPHERES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && (cmd_op == pis_pkg::OP_QUERY)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      v_rd      <= 1'b0;
      v_sq      <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        count <= count + CW'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop_fire) begin
        res_valid <= 1'b0;
      end
      v_rd <= issue;
      v_sq <= v_rd;
    end
  end

  // Latch the query and clear the scan on entry.
  always_ff @(posedge clk) begin
    if (cmd_take && (cmd_op == pis_pkg::OP_QUERY)) begin
      px       <= cmd_x;
      py       <= cmd_y;
      pz       <= cmd_z;
      pkind    <= cmd_kind;
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + CW'(1);
    end
  end

  assign {ek, er, ez, ey, ex} = rdata;
  assign dx = (px >= ex) ? (px - ex) : (ex - px);
  assign dy = (py >= ey) ? (py - ey) : (ey - py);
  assign dz = (pz >= ez) ? (pz - ez) : (ez - pz);

  // Stage one: squares of the distances and the radius.
  always_ff @(posedge clk) begin
    sqx    <= dx * dx;
    sqy    <= dy * dy;
    sqz    <= dz * dz;
    r2     <= er * er;
    kmatch <= (ek == pkind);
  end

  assign d2 = SW'(sqx) + SW'(sqy) + SW'(sqz);

  // Stage two: sum, compare and accumulate.
  always_ff @(posedge clk) begin
    if (cmd_take && (cmd_op == pis_pkg::OP_QUERY)) begin
      hit_acc <= 1'b0;
    end else if (v_sq && kmatch && (d2 < SW'(r2))) begin
      hit_acc <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if (state == S_DONE) begin
        hit    <= hit_acc;
        status <= pis_pkg::STATUS_OK;
      end else begin
        hit    <= 1'b0;
        status <= tbl_full ? pis_pkg::STATUS_DROPPED : pis_pkg::STATUS_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SPHERES))
    else $error("sphere count above table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= count))
    else $error("scan index ran past the stored spheres");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (add_fire && !tbl_full) |=> (count == $past(count) + CW'(1)))
    else $error("stored add did not advance the count");

  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !res_load)
    else $error("result loaded while a scan is in flight");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!v_rd && !v_sq))
    else $error("scan pipeline not drained at completion");
`endif

endmodule

`default_nettype wire
